/* rtl/hbc_pkg.sv */
// Types and constants shared by the buffer cache table modules.
package hbc_pkg;

  localparam int unsigned DevW = 4;
  localparam int unsigned BlkW = 24;
  localparam int unsigned IdxW = 5;
  localparam int unsigned CntW = 8;
  localparam int unsigned StatW = 3;
  localparam int unsigned BktW = 4;
  localparam int unsigned RankW = 8;

  typedef enum logic [1:0] {
    MODE_GET     = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_PIN     = 2'd2,
    MODE_UNPIN   = 2'd3
  } mode_t;

  typedef enum logic [StatW-1:0] {
    ST_HIT       = 3'd0,
    ST_MISS      = 3'd1,
    ST_NO_FREE   = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]      mode;
    logic [DevW-1:0] device;
    logic [BlkW-1:0] block_number;
    logic [IdxW-1:0] buffer_index;
  } req_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [IdxW-1:0]  slot;
    logic [CntW-1:0]  reference_count;
  } rsp_t;

  // Candidate travelling along the chain of cells during the search sweep.
  typedef struct packed {
    logic            hit_found;
    logic [7:0]      hit_slot;
    logic [RankW-1:0] hit_rank;
    logic [CntW-1:0] hit_cnt;
    logic            hit_valid;
    logic            free_found;
    logic [7:0]      free_slot;
    logic [BktW-1:0] free_bkt;
    logic [RankW-1:0] free_rank;
  } cand_t;

  // Update command broadcast to every cell.
  typedef struct packed {
    logic            en_cnt;
    logic            en_tag;
    logic            en_valid;
    logic            en_mru;
    logic [7:0]      sel;
    logic [CntW-1:0] cnt;
    logic [DevW-1:0] dev;
    logic [BlkW-1:0] blk;
    logic [BktW-1:0] bkt;
    logic [RankW-1:0] old_rank;
  } upd_t;

endpackage

/* rtl/hbc_cell.sv */
// One buffer slot: tag, count, valid, bucket and recency rank, plus its chain stage.
module hbc_cell #(
  parameter int unsigned SLOT = 0,
  parameter int unsigned NBUF = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  hbc_pkg::cand_t    cand_in,
  output hbc_pkg::cand_t    cand_out,
  input  logic [hbc_pkg::DevW-1:0] q_dev,
  input  logic [hbc_pkg::BlkW-1:0] q_blk,
  input  logic [hbc_pkg::BktW-1:0] q_bkt,
  input  hbc_pkg::upd_t     upd,
  output logic [hbc_pkg::CntW-1:0] cnt_o,
  output logic [hbc_pkg::RankW-1:0] rank_o
);
  import hbc_pkg::*;

  logic [DevW-1:0]  tdev;
  logic [BlkW-1:0]  tblk;
  logic [CntW-1:0]  cnt;
  logic             vld;
  logic [BktW-1:0]  bkt;
  logic [RankW-1:0] rank;
  logic             me, match, better_hit, better_free;
  cand_t            cand_next;

  assign me = (upd.sel == 8'(SLOT));
  assign match = (bkt == q_bkt) && (tdev == q_dev) && (tblk == q_blk);
  assign better_hit = match && (!cand_in.hit_found || rank > cand_in.hit_rank);
  assign better_free = (cnt == '0) && (!cand_in.free_found || bkt < cand_in.free_bkt ||
                       (bkt == cand_in.free_bkt && rank < cand_in.free_rank));

  always_comb begin
    cand_next = cand_in;
    if (better_hit) begin
      cand_next.hit_found = 1'b1;
      cand_next.hit_slot  = 8'(SLOT);
      cand_next.hit_rank  = rank;
      cand_next.hit_cnt   = cnt;
      cand_next.hit_valid = vld;
    end
    if (better_free) begin
      cand_next.free_found = 1'b1;
      cand_next.free_slot  = 8'(SLOT);
      cand_next.free_bkt   = bkt;
      cand_next.free_rank  = rank;
    end
  end

  always_ff @(posedge clk) begin
    cand_out <= cand_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tdev <= '0;
      tblk <= '0;
      cnt  <= '0;
      vld  <= 1'b0;
      bkt  <= '0;
      rank <= RankW'(SLOT);
    end else begin
      if (me && upd.en_cnt) cnt <= upd.cnt;
      if (me && upd.en_valid) vld <= 1'b1;
      if (me && upd.en_tag) begin
        tdev <= upd.dev;
        tblk <= upd.blk;
        bkt  <= upd.bkt;
      end
      if (upd.en_mru) begin
        if (me) rank <= RankW'(NBUF - 1);
        else if (rank > upd.old_rank) rank <= rank - 1'b1;
      end
    end
  end

  assign cnt_o = cnt;
  assign rank_o = rank;
endmodule

/* rtl/hashed_buffer_cache_lru_core.sv */
// Top level of the hashed buffer cache tag and LRU policy table.
//  channel | dir | handshake       | payload
//  req     | in  | req_valid/stall | hbc_pkg::req_t
//  rsp     | out | rsp_valid/stall | hbc_pkg::rsp_t
// A get ripples a candidate through the chain of NUM_BUFFERS slot cells, one cell a
// cycle, after a reciprocal-multiply hash; it passes through IDLE, HASH, SWEEP and DONE.
// Release, pin and unpin go from HASH straight to DONE and skip the sweep.
// Reset returns all slots to bucket 0, count 0, invalid, rank equal to slot index.
// A stalled result holds in the output register; the next item is taken meanwhile
// and its result waits in DONE until the register drains.
module hashed_buffer_cache_lru_core #(
  parameter int unsigned NUM_BUFFERS = 32,
  parameter int unsigned NUM_BUCKETS = 13
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  hbc_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output hbc_pkg::rsp_t  rsp
);
  import hbc_pkg::*;

  localparam int unsigned SW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int unsigned HashShift = BlkW + BktW;
  localparam int unsigned ProdW = BlkW + HashShift + 1;
  localparam longint unsigned HashMul =
    ((64'd1 << HashShift) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_HASH  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;
  req_t   q;
  logic [BktW-1:0] hash;
  logic [BlkW-1:0] key;
  logic [ProdW-1:0] prod;
  logic [BlkW-1:0] quo;
  logic [BlkW-1:0] rem_full;
  logic [8:0]      cyc;
  logic            rsp_full;
  rsp_t            res;
  logic            res_ready;
  upd_t            upd;
  cand_t           chain [NUM_BUFFERS+1];
  logic [CntW-1:0]  cnts  [NUM_BUFFERS];
  logic [RankW-1:0] ranks [NUM_BUFFERS];
  logic [SW-1:0]   idx;

  assign key = q.block_number ^ BlkW'(q.device);
  assign prod = ProdW'(key) * ProdW'(HashMul);
  assign rem_full = key - quo * BlkW'(NUM_BUCKETS);
  assign idx = q.buffer_index[SW-1:0];
  assign chain[0] = '0;

  for (genvar g = 0; g < NUM_BUFFERS; g++) begin : g_cell
    hbc_cell #(.SLOT(g), .NBUF(NUM_BUFFERS)) u_cell (
      .clk(clk), .rst(rst),
      .cand_in(chain[g]), .cand_out(chain[g+1]),
      .q_dev(q.device), .q_blk(q.block_number), .q_bkt(hash),
      .upd(upd), .cnt_o(cnts[g]), .rank_o(ranks[g])
    );
  end

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req_valid) state_next = S_HASH;
      S_HASH:  state_next = (q.mode == MODE_GET) ? S_SWEEP : S_DONE;
      S_SWEEP: if (cyc == 9'(NUM_BUFFERS + 1)) state_next = S_DONE;
      S_DONE:  if (!rsp_full || !rsp_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign res_ready = (state == S_DONE) && (!rsp_full || !rsp_stall);

  always_comb begin
    cand_t c;
    c = chain[NUM_BUFFERS];
    upd = '0;
    res = '0;
    if (q.mode == MODE_GET) begin
      if (c.hit_found) begin
        res.slot = IdxW'(c.hit_slot);
        if (c.hit_cnt == '1) begin
          res.status = ST_OVERFLOW;
          res.reference_count = '1;
        end else begin
          res.status = c.hit_valid ? ST_HIT : ST_MISS;
          res.reference_count = c.hit_cnt + 1'b1;
          upd.en_cnt = 1'b1;
          upd.en_valid = 1'b1;
          upd.sel = c.hit_slot;
          upd.cnt = c.hit_cnt + 1'b1;
        end
      end else if (c.free_found) begin
        res.status = ST_MISS;
        res.slot = IdxW'(c.free_slot);
        res.reference_count = CntW'(1);
        upd.en_cnt = 1'b1;
        upd.en_valid = 1'b1;
        upd.en_tag = 1'b1;
        upd.en_mru = 1'b1;
        upd.sel = c.free_slot;
        upd.cnt = CntW'(1);
        upd.dev = q.device;
        upd.blk = q.block_number;
        upd.bkt = hash;
        upd.old_rank = c.free_rank;
      end else begin
        res.status = ST_NO_FREE;
      end
    end else begin
      res.slot = IdxW'(idx);
      upd.sel = 8'(idx);
      upd.old_rank = ranks[idx];
      if (q.mode == MODE_PIN) begin
        if (cnts[idx] == '1) begin
          res.status = ST_OVERFLOW;
          res.reference_count = '1;
        end else begin
          res.reference_count = cnts[idx] + 1'b1;
          upd.en_cnt = 1'b1;
          upd.cnt = cnts[idx] + 1'b1;
        end
      end else if (cnts[idx] == '0) begin
        res.status = ST_UNDERFLOW;
      end else begin
        res.reference_count = cnts[idx] - 1'b1;
        upd.en_cnt = 1'b1;
        upd.cnt = cnts[idx] - 1'b1;
        upd.en_mru = (q.mode == MODE_RELEASE) && (cnts[idx] == CntW'(1));
      end
    end
    if (!res_ready) upd = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_full <= 1'b0;
      cyc <= '0;
    end else begin
      state <= state_next;
      cyc <= (state == S_SWEEP) ? cyc + 1'b1 : '0;
      if (res_ready) rsp_full <= 1'b1;
      else if (!rsp_stall) rsp_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) q <= req;
    if (state == S_HASH) quo <= prod[HashShift +: BlkW];
    if (state == S_SWEEP && cyc == '0) hash <= rem_full[BktW-1:0];
    if (res_ready) rsp <= res;
  end

  assign rsp_valid = rsp_full;
endmodule
